>>> hdl/ossvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_pkg
// Shared types, codes and helpers of the one-shot sample voice mixer.
// ----------------------------------------------------------------------------
package ossvm_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int SLOT_WORDS_DEF = 4096;

  localparam int REQ_W    = 3;
  localparam int NOTE_W   = 7;
  localparam int OFFS_W   = 12;
  localparam int LENF_W   = 13;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 5;
  localparam int COUNT_MAX = 31;

  typedef enum logic [REQ_W-1:0] {
    OP_NOTE_ON  = 3'd0,
    OP_NOTE_OFF = 3'd1,
    OP_TICK     = 3'd2,
    OP_LOAD     = 3'd3,
    OP_SET_LEN  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [NOTE_W-1:0]          note;
    logic [OFFS_W-1:0]          offset;
    logic [LENF_W-1:0]          length;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } cmd_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ossvm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ossvm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [6:0]         note;
  logic [11:0]        word_offset;
  logic signed [15:0] sample_word;
  logic               set_length_zero;
  logic signed [15:0] mix_in_left;
  logic signed [15:0] mix_in_right;

  modport source (output valid, req_type, note, word_offset, sample_word,
                  set_length_zero, mix_in_left, mix_in_right, input ready);
  modport sink (input valid, req_type, note, word_offset, sample_word,
                set_length_zero, mix_in_left, mix_in_right, output ready);
endinterface

interface ossvm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_out_left;
  logic signed [15:0] mix_out_right;
  logic [4:0]         voices_playing;

  modport source (output valid, mix_out_left, mix_out_right, voices_playing,
                  input ready);
  modport sink (input valid, mix_out_left, mix_out_right, voices_playing,
                output ready);
endinterface

interface ossvm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot_count;

  modport source (output valid, slot_count, input ready);
  modport sink (input valid, slot_count, output ready);
endinterface

>>> hdl/ossvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ossvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ossvm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_front
// Accepts request words, holds slot_count, drops ignored requests and
// turns the rest into commands for the queue.
// ----------------------------------------------------------------------------
module ossvm_front import ossvm_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int SLOT_WORDS = SLOT_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ossvm_req_if.sink   request,
  ossvm_cfg_if.sink   cfg,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [COUNT_W-1:0] slot_count;
  logic               keep;
  logic               note_ok;
  logic               note_counted;
  logic [31:0]        len_full;

  assign cfg.ready     = 1'b1;
  assign request.ready = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
    end else if (cfg.valid) begin
      slot_count <= cfg.slot_count;
    end
  end

  always_comb begin
    note_ok      = 32'(request.note) < 32'(NUM_SLOTS);
    note_counted = note_ok && (32'(request.note) < 32'(slot_count));
    len_full     = 32'(request.word_offset) + 32'd1;
    if (len_full > 32'(SLOT_WORDS)) begin
      len_full = 32'(SLOT_WORDS);
    end
    if (request.set_length_zero) begin
      len_full = '0;
    end

    push_cmd.op     = OP_TICK;
    push_cmd.note   = request.note;
    push_cmd.offset = request.word_offset;
    push_cmd.length = len_full[LENF_W-1:0];
    push_cmd.sample = request.sample_word;
    push_cmd.left   = request.mix_in_left;
    push_cmd.right  = request.mix_in_right;
    keep            = 1'b0;

    unique case (request.req_type)
      OP_NOTE_ON: begin
        push_cmd.op = OP_NOTE_ON;
        keep        = note_counted;
      end
      OP_NOTE_OFF: begin
        push_cmd.op = OP_NOTE_OFF;
        keep        = note_counted;
      end
      OP_TICK: begin
        push_cmd.op = OP_TICK;
        keep        = 1'b1;
      end
      OP_LOAD: begin
        push_cmd.op = OP_LOAD;
        keep        = note_ok && (32'(request.word_offset) < 32'(SLOT_WORDS));
      end
      OP_SET_LEN: begin
        push_cmd.op = OP_SET_LEN;
        keep        = note_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = request.valid && request.ready && keep;

endmodule

>>> hdl/ossvm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ossvm_queue import ossvm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = fill == 2'd2;
  assign head_valid = fill != 2'd0;
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> hdl/ossvm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_back
// Executes commands: note and length updates, sample loads, and the tick
// walk over all voices through the length, position and sample RAMs.
// ----------------------------------------------------------------------------
module ossvm_back import ossvm_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int SLOT_WORDS = SLOT_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  ossvm_rsp_if.source result
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W   = $clog2(SLOT_WORDS);
  localparam int LEN_W   = $clog2(SLOT_WORDS + 1);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int ACC_W   = SAMPLE_W + CNT_W + 1;
  localparam int SAMP_AW = SLOT_W + POS_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic                    active [NUM_SLOTS];
  logic                    len_nz [NUM_SLOTS];

  logic                    issue_on;
  logic [SLOT_W-1:0]       issue_idx;
  logic                    b_valid;
  logic [SLOT_W-1:0]       b_slot;
  logic                    c_valid;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0]        playing;

  logic [SLOT_W-1:0]       cmd_slot;
  logic [POS_W-1:0]        pos_rd;
  logic [LEN_W-1:0]        len_rd;
  logic [LEN_W-1:0]        pos_inc;
  logic                    b_act;
  logic                    b_play;
  logic                    b_fin;
  logic [POS_W-1:0]        pos_new;
  logic                    pos_we;
  logic [SLOT_W-1:0]       pos_waddr;
  logic [POS_W-1:0]        pos_wdata;
  logic                    len_we;
  logic                    samp_we;
  logic [SAMP_AW-1:0]      samp_waddr;
  logic [SAMP_AW-1:0]      samp_raddr;
  logic [SAMPLE_W-1:0]     samp_rd;
  logic signed [ACC_W-1:0] samp_ext;

  assign pop      = (state == ST_IDLE) && head_valid;
  assign cmd_slot = SLOT_W'(head.note);

  assign b_act   = active[b_slot];
  assign pos_inc = LEN_W'(pos_rd) + LEN_W'(1);
  assign b_play  = b_act && (LEN_W'(pos_rd) < len_rd);
  assign b_fin   = pos_inc >= len_rd;
  assign pos_new = b_fin ? '0 : POS_W'(pos_inc);

  assign len_we     = pop && (head.op == OP_SET_LEN);
  assign samp_we    = pop && (head.op == OP_LOAD);
  assign samp_waddr = {cmd_slot, POS_W'(head.offset)};
  assign samp_raddr = {b_slot, pos_rd};
  assign samp_ext   = {{(ACC_W-SAMPLE_W){samp_rd[SAMPLE_W-1]}}, samp_rd};

  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = cmd_slot;
    pos_wdata = '0;
    if (b_valid) begin
      pos_we    = b_act;
      pos_waddr = b_slot;
      pos_wdata = pos_new;
    end else if (pop) begin
      pos_we = ((head.op == OP_NOTE_ON) && len_nz[cmd_slot]) || (head.op == OP_SET_LEN);
    end
  end

  ossvm_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (cmd_slot),
    .wdata (LEN_W'(head.length)),
    .raddr (issue_idx),
    .rdata (len_rd)
  );

  ossvm_ram #(.WIDTH(POS_W), .DEPTH(NUM_SLOTS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (issue_idx),
    .rdata (pos_rd)
  );

  ossvm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** SAMP_AW)) u_sample_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (head.sample),
    .raddr (samp_raddr),
    .rdata (samp_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && (head.op == OP_TICK)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!issue_on && !b_valid && !c_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result.valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issue_on <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        active[i] <= 1'b0;
        len_nz[i] <= 1'b0;
      end
    end else begin
      state <= state_next;

      if (pop) begin
        case (head.op)
          OP_NOTE_ON: begin
            if (len_nz[cmd_slot]) begin
              active[cmd_slot] <= 1'b1;
            end
          end
          OP_NOTE_OFF: begin
            active[cmd_slot] <= 1'b0;
          end
          OP_SET_LEN: begin
            active[cmd_slot] <= 1'b0;
            len_nz[cmd_slot] <= head.length != '0;
          end
          OP_TICK: begin
            issue_on <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (issue_on) begin
        b_valid <= 1'b1;
        if (issue_idx == LAST_SLOT) begin
          issue_on <= 1'b0;
        end
      end else begin
        b_valid <= 1'b0;
      end

      c_valid <= b_valid && b_play;
      if (b_valid && b_act) begin
        active[b_slot] <= !b_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_TICK)) begin
      issue_idx <= '0;
      acc_l     <= {{(ACC_W-SAMPLE_W){head.left[SAMPLE_W-1]}}, head.left};
      acc_r     <= {{(ACC_W-SAMPLE_W){head.right[SAMPLE_W-1]}}, head.right};
      playing   <= '0;
    end else begin
      if (issue_on && (issue_idx != LAST_SLOT)) begin
        issue_idx <= issue_idx + SLOT_W'(1);
      end
      if (b_valid && b_act && !b_fin) begin
        playing <= playing + CNT_W'(1);
      end
      if (c_valid) begin
        acc_l <= acc_l + samp_ext;
        acc_r <= acc_r + samp_ext;
      end
    end
    if (issue_on) begin
      b_slot <= issue_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if ((state == ST_DONE) && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!result.valid || result.ready)) begin
      result.mix_out_left  <= sat16({{(32-ACC_W){acc_l[ACC_W-1]}}, acc_l});
      result.mix_out_right <= sat16({{(32-ACC_W){acc_r[ACC_W-1]}}, acc_r});
      result.voices_playing <= (32'(playing) > 32'(COUNT_MAX)) ?
                               COUNT_W'(COUNT_MAX) : COUNT_W'(playing);
    end
  end

endmodule

>>> hdl/one_shot_sample_voice_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_sample_voice_mixer
// Polyphonic one-shot sample player with stereo saturating mix.
// Tick: the back end walks all slots one per cycle through the length,
// position and sample RAM read pipeline and takes no other request
// until done; other requests act as they leave the queue. A two-word
// queue lets requests enter meanwhile.
// Reset: synchronous; clears voices, lengths and slot_count; samples keep.
// ----------------------------------------------------------------------------
module one_shot_sample_voice_mixer import ossvm_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int SLOT_WORDS = SLOT_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ossvm_cfg_if.sink    cfg,
  ossvm_req_if.sink    request,
  ossvm_rsp_if.source  result
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  ossvm_front #(.NUM_SLOTS(NUM_SLOTS), .SLOT_WORDS(SLOT_WORDS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ossvm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ossvm_back #(.NUM_SLOTS(NUM_SLOTS), .SLOT_WORDS(SLOT_WORDS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> hdl/ossvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossvm_checker
// Port-level checks of the voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ossvm_checker import ossvm_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [2:0]         req_type,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [15:0] mix_out_left,
  input logic [4:0]         voices_playing
);

  localparam int VOICE_CAP = (NUM_SLOTS < COUNT_MAX) ? NUM_SLOTS : COUNT_MAX;

  logic [7:0] pending;
  logic       tick_in;
  logic       rsp_out;

  assign tick_in = req_valid && req_ready && (req_type == OP_TICK);
  assign rsp_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (tick_in && !rsp_out) begin
      pending <= pending + 8'd1;
    end else if (rsp_out && !tick_in) begin
      pending <= pending - 8'd1;
    end
  end

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 8'd0)
    else $error("result without an outstanding tick");

  a_voice_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(voices_playing) <= 32'(VOICE_CAP))
    else $error("voices_playing above slot count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(mix_out_left))
    else $error("stalled result dropped or changed");

endmodule

bind one_shot_sample_voice_mixer ossvm_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (request.valid),
  .req_ready      (request.ready),
  .req_type       (request.req_type),
  .rsp_valid      (result.valid),
  .rsp_ready      (result.ready),
  .mix_out_left   (result.mix_out_left),
  .voices_playing (result.voices_playing)
);
